### sv/qmlw_pkg.sv
// Shared types, register codes and reset values for the quad motor lag wrench step block.
package qmlw_pkg;

  // Fraction bits of the stored motor speed
  localparam int unsigned SpeedFracBitsDef = 16;

  // Motor count and field widths
  localparam int unsigned NumMotors = 4;
  localparam int unsigned CmdW      = 16;
  localparam int unsigned SqW       = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 18;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 144;

  // Register reset values
  localparam logic [13:0] MinSpeedRst    = 14'd1500;
  localparam logic [13:0] MaxSpeedRst    = 14'd7500;
  localparam logic [15:0] LagGainRst     = 16'd1311;
  localparam logic [17:0] ThrustCoeffRst = 18'd61023;
  localparam logic [17:0] ArmCoeffRst    = 18'd10374;
  localparam logic [17:0] YawCoeffRst    = 18'd846;

  // Register indexes on the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_SPEED    = 3'd0,
    REG_MAX_SPEED    = 3'd1,
    REG_LAG_GAIN     = 3'd2,
    REG_THRUST_COEFF = 3'd3,
    REG_ARM_COEFF    = 3'd4,
    REG_YAW_COEFF    = 3'd5
  } reg_idx_e;

  // Configuration register file
  typedef struct packed {
    logic [13:0] min_speed;
    logic [13:0] max_speed;
    logic [15:0] lag_gain;
    logic [17:0] thrust_coeff;
    logic [17:0] arm_coeff;
    logic [17:0] yaw_coeff;
  } cfg_t;

  // Wrench result handed from the wrench unit to the output register
  typedef struct packed {
    logic               valid;
    logic        [19:0] thrust;
    logic signed [17:0] roll;
    logic signed [17:0] pitch;
    logic signed [17:0] yaw;
  } res_t;

endpackage

### sv/qmlw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module qmlw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/qmlw_motor.sv
// Motor speed unit: read, lag update and write back of the speed memory, then squares.
module qmlw_motor #(
  parameter int unsigned SPEED_FRAC_BITS = qmlw_pkg::SpeedFracBitsDef
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  start_i,
  input  logic                                                  preset_i,
  input  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::CmdW-1:0]    cmd_i,
  input  qmlw_pkg::cfg_t                                        cfg_i,
  output logic                                                  done_o,
  output logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::SqW-1:0]     sq_o,
  output logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::CmdW-1:0]    speed_o
);

  localparam int unsigned SpW   = qmlw_pkg::CmdW + SPEED_FRAC_BITS;
  localparam int unsigned ProdW = SpW + 1 + 17;
  localparam int unsigned DeltW = ProdW - 16;
  localparam int unsigned IdxW  = $clog2(qmlw_pkg::NumMotors);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(qmlw_pkg::NumMotors - 1);

  // Request latch
  logic                                               preset_q;
  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::CmdW-1:0] cmd_q;

  // Issue stage
  logic            iss_act_q, iss_act_d;
  logic [IdxW-1:0] iss_idx_q, iss_idx_d;
  logic [qmlw_pkg::NumMotors-1:0] ent_vld_q;

  // Multiply stage
  logic            s1_vld_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_ent_q;

  // Write back stage
  logic                    s2_vld_q;
  logic [IdxW-1:0]         s2_idx_q;
  logic [SpW-1:0]          s2_cur_q;
  logic signed [ProdW-1:0] s2_prod_q;

  // Square stage
  logic                      s3_vld_q;
  logic [IdxW-1:0]           s3_idx_q;
  logic [qmlw_pkg::CmdW-1:0] s3_whole_q;

  logic                                               done_q;
  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::SqW-1:0]  sq_q;
  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::CmdW-1:0] speed_q;

  logic [SpW-1:0]            rdata;
  logic [SpW-1:0]            cur;
  logic [qmlw_pkg::CmdW-1:0] cmd_sel;
  logic [qmlw_pkg::CmdW-1:0] cmd_clamp;
  logic [SpW-1:0]            target;
  logic signed [SpW:0]       diff;
  logic signed [ProdW-1:0]   prod;
  logic signed [DeltW-1:0]   delta;
  logic signed [DeltW-1:0]   sum;
  logic [SpW-1:0]            new_speed;
  logic [SpW-1:0]            preset_speed;

  qmlw_ram #(
    .WIDTH (SpW),
    .DEPTH (qmlw_pkg::NumMotors)
  ) u_speed_ram (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (s2_idx_q),
    .wdata_i (new_speed),
    .re_i    (iss_act_q),
    .raddr_i (iss_idx_q),
    .rdata_o (rdata)
  );

  // Advance the read address over the four motors
  always_comb begin
    iss_act_d = iss_act_q;
    iss_idx_d = iss_idx_q;
    if (start_i) begin
      iss_act_d = 1'b1;
      iss_idx_d = '0;
    end else if (iss_act_q) begin
      iss_idx_d = iss_idx_q + 1'b1;
      if (iss_idx_q == LastIdx) begin
        iss_act_d = 1'b0;
      end
    end
  end

  // Clamp the command and form the lag product
  always_comb begin
    cur     = s1_ent_q ? rdata : '0;
    cmd_sel = cmd_q[s1_idx_q];
    if (cmd_sel > {2'b00, cfg_i.max_speed}) begin
      cmd_clamp = {2'b00, cfg_i.max_speed};
    end else if (cmd_sel < {2'b00, cfg_i.min_speed}) begin
      cmd_clamp = {2'b00, cfg_i.min_speed};
    end else begin
      cmd_clamp = cmd_sel;
    end
    target = {cmd_clamp, {SPEED_FRAC_BITS{1'b0}}};
    diff   = $signed({1'b0, target}) - $signed({1'b0, cur});
    prod   = ProdW'(diff * $signed({1'b0, cfg_i.lag_gain}));
  end

  // Apply the floored delta, or load the preset speed
  always_comb begin
    delta        = DeltW'(s2_prod_q >>> 16);
    sum          = $signed({2'b00, s2_cur_q}) + delta;
    preset_speed = {cmd_q[s2_idx_q], {SPEED_FRAC_BITS{1'b0}}};
    new_speed    = preset_q ? preset_speed : sum[SpW-1:0];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      iss_idx_q <= '0;
      ent_vld_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      iss_act_q <= iss_act_d;
      iss_idx_q <= iss_idx_d;
      s1_vld_q  <= iss_act_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      done_q    <= s3_vld_q && (s3_idx_q == LastIdx);
      if (s2_vld_q) begin
        ent_vld_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      preset_q <= preset_i;
      cmd_q    <= cmd_i;
    end
    s1_idx_q   <= iss_idx_q;
    s1_ent_q   <= ent_vld_q[iss_idx_q];
    s2_idx_q   <= s1_idx_q;
    s2_cur_q   <= cur;
    s2_prod_q  <= prod;
    s3_idx_q   <= s2_idx_q;
    s3_whole_q <= new_speed[SpW-1:SPEED_FRAC_BITS];
    if (s2_vld_q) begin
      speed_q[s2_idx_q] <= new_speed[SpW-1:SPEED_FRAC_BITS];
    end
    if (s3_vld_q) begin
      sq_q[s3_idx_q] <= s3_whole_q * s3_whole_q;
    end
  end

  assign done_o  = done_q;
  assign sq_o    = sq_q;
  assign speed_o = speed_q;

  // Read and write back never touch the same entry in one cycle
  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss_act_q && s2_vld_q) |-> (iss_idx_q != s2_idx_q))
    else $error("speed memory read and write hit the same entry");

  // A new request only enters an empty pipeline
  a_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !(iss_act_q || s1_vld_q || s2_vld_q || s3_vld_q))
    else $error("request started while motor pipeline busy");

  // Completion is a single pulse per request
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("motor completion repeated");

endmodule

### sv/qmlw_wrench.sv
// Wrench unit: sums of squares, coefficient products and output saturation.
module qmlw_wrench (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              done_i,
  input  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::SqW-1:0] sq_i,
  input  qmlw_pkg::cfg_t                                    cfg_i,
  input  logic                                              take_i,
  output qmlw_pkg::res_t                                    res_o
);

  // Saturate a floored value to the signed 18 bit range
  function automatic logic signed [17:0] sat_s18(input logic signed [29:0] v);
    logic signed [17:0] r;
    if (v > 30'sd131071) begin
      r = 18'sd131071;
    end else if (v < -30'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  logic               sum_vld_q;
  logic [33:0]        tot_q;
  logic signed [32:0] rd_q;
  logic signed [32:0] pd_q;
  logic signed [34:0] yd_q;

  logic               prod_vld_q;
  logic [51:0]        tp_q;
  logic signed [51:0] rp_q;
  logic signed [51:0] pp_q;
  logic signed [53:0] yp_q;

  logic [27:0]        thr_sh;

  // Hold product valid until the output register takes the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= done_i;
      if (sum_vld_q) begin
        prod_vld_q <= 1'b1;
      end else if (take_i) begin
        prod_vld_q <= 1'b0;
      end
    end
  end

  // Register sums, then products
  always_ff @(posedge clk_i) begin
    if (done_i) begin
      tot_q <= {2'b00, sq_i[0]} + {2'b00, sq_i[1]} + {2'b00, sq_i[2]} + {2'b00, sq_i[3]};
      rd_q  <= $signed({1'b0, sq_i[2]}) - $signed({1'b0, sq_i[3]});
      pd_q  <= $signed({1'b0, sq_i[1]}) - $signed({1'b0, sq_i[0]});
      yd_q  <= $signed({3'b000, sq_i[0]}) + $signed({3'b000, sq_i[1]})
             - $signed({3'b000, sq_i[2]}) - $signed({3'b000, sq_i[3]});
    end
    if (sum_vld_q) begin
      tp_q <= tot_q * {16'd0, cfg_i.thrust_coeff};
      rp_q <= 52'(rd_q * $signed({1'b0, cfg_i.arm_coeff}));
      pp_q <= 52'(pd_q * $signed({1'b0, cfg_i.arm_coeff}));
      yp_q <= 54'(yd_q * $signed({1'b0, cfg_i.yaw_coeff}));
    end
  end

  // Shift down by 24 and saturate
  always_comb begin
    thr_sh       = tp_q[51:24];
    res_o.valid  = prod_vld_q;
    res_o.thrust = (|thr_sh[27:20]) ? 20'hFFFFF : thr_sh[19:0];
    res_o.roll   = sat_s18(30'(rp_q >>> 24));
    res_o.pitch  = sat_s18(30'(pp_q >>> 24));
    res_o.yaw    = sat_s18(yp_q[53:24]);
  end

endmodule

### sv/quad_motor_lag_wrench_step.sv
// Top level of the quad motor lag wrench step block: channels, registers, output register.
//
//   channel  direction  handshake                      payload
//   s_axis   in         s_axis_tvalid_i/tready_o       tdata commands, tuser opcode
//   m_axis   out        m_axis_tvalid_o/tready_i       tdata wrench and speeds
//   cfg      in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// From acceptance to the result landing in the output register, a request passes through
// four reads of the speed memory, the lag multiply, write back, squaring, then the sum
// and product stages and the saturation of the wrench unit.
// The next request is accepted in the cycle after the result enters the output register,
// so a waiting result does not block it. Reset clears all speeds to zero through per-entry
// valid bits and loads the register reset values. A stalled output delays the hand-over of
// the next result and the intake of new requests; configuration writes are always taken.
module quad_motor_lag_wrench_step #(
  parameter int unsigned SPEED_FRAC_BITS = qmlw_pkg::SpeedFracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // speed_cmd_0, speed_cmd_1, speed_cmd_2, speed_cmd_3
  input  logic [qmlw_pkg::InDataW-1:0]    s_axis_tdata_i,
  // opcode
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // thrust, roll_moment, pitch_moment, yaw_moment, speed_now_0..3, zero pad
  output logic [qmlw_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qmlw_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [qmlw_pkg::CfgDataW-1:0]   cfg_data_i
);

  qmlw_pkg::cfg_t cfg_q;
  logic           busy_q;
  logic           m_vld_q;
  logic [qmlw_pkg::OutDataW-1:0] m_data_q;

  logic           in_acc;
  logic           cfg_acc;
  logic           load;
  logic           done;
  qmlw_pkg::res_t res;
  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::SqW-1:0]  sq;
  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::CmdW-1:0] speed;
  logic [qmlw_pkg::NumMotors-1:0][qmlw_pkg::CmdW-1:0] cmd;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy_q;
  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;
  assign load            = res.valid && (!m_vld_q || m_axis_tready_i);
  assign cmd             = s_axis_tdata_i;

  qmlw_motor #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_motor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .preset_i (s_axis_tuser_i),
    .cmd_i    (cmd),
    .cfg_i    (cfg_q),
    .done_o   (done),
    .sq_o     (sq),
    .speed_o  (speed)
  );

  qmlw_wrench u_wrench (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .done_i (done),
    .sq_i   (sq),
    .cfg_i  (cfg_q),
    .take_i (load),
    .res_o  (res)
  );

  // Hold configuration; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed    <= qmlw_pkg::MinSpeedRst;
      cfg_q.max_speed    <= qmlw_pkg::MaxSpeedRst;
      cfg_q.lag_gain     <= qmlw_pkg::LagGainRst;
      cfg_q.thrust_coeff <= qmlw_pkg::ThrustCoeffRst;
      cfg_q.arm_coeff    <= qmlw_pkg::ArmCoeffRst;
      cfg_q.yaw_coeff    <= qmlw_pkg::YawCoeffRst;
    end else if (cfg_acc) begin
      case (qmlw_pkg::reg_idx_e'(cfg_index_i))
        qmlw_pkg::REG_MIN_SPEED:    cfg_q.min_speed    <= cfg_data_i[13:0];
        qmlw_pkg::REG_MAX_SPEED:    cfg_q.max_speed    <= cfg_data_i[13:0];
        qmlw_pkg::REG_LAG_GAIN:     cfg_q.lag_gain     <= cfg_data_i[15:0];
        qmlw_pkg::REG_THRUST_COEFF: cfg_q.thrust_coeff <= cfg_data_i;
        qmlw_pkg::REG_ARM_COEFF:    cfg_q.arm_coeff    <= cfg_data_i;
        qmlw_pkg::REG_YAW_COEFF:    cfg_q.yaw_coeff    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Track the request in flight and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Pack the result
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {6'd0, speed[3], speed[2], speed[1], speed[0],
                   res.yaw, res.pitch, res.roll, res.thrust};
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;

  // A result only moves out for a request in flight
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> busy_q)
    else $error("result loaded with no request in flight");

endmodule

### verif/testbench.sv
// Self-checking testbench for quad_motor_lag_wrench_step: directed table, then phased random traffic.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FracBits      = qmlw_pkg::SpeedFracBitsDef;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainCycles   = 33;
  localparam int unsigned CycleLimit    = 400000;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [qmlw_pkg::CfgIdxW-1:0] IdxSpare6 = 3'd6;
  localparam logic [qmlw_pkg::CfgIdxW-1:0] IdxSpare7 = 3'd7;

  // Saturation bounds of the result fields
  localparam logic        [19:0] ThrustSat = 20'hFFFFF;
  localparam logic signed [17:0] MomentHi  = 18'sh1FFFF;
  localparam logic signed [17:0] MomentLo  = 18'sh20000;

  typedef enum logic {OP_STEP, OP_PRESET} op_e;
  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct packed {
    logic        [19:0]      thrust;
    logic signed [17:0]      roll;
    logic signed [17:0]      pitch;
    logic signed [17:0]      yaw;
    logic        [0:3][15:0] speed_now;
  } wrench_t;

  typedef struct packed {
    row_kind_e                     kind;
    op_e                           op;
    logic [0:3][15:0]              cmds;
    logic [qmlw_pkg::CfgIdxW-1:0]  reg_idx;
    logic [qmlw_pkg::CfgDataW-1:0] reg_val;
    logic                          typed;
    wrench_t                       expected;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [qmlw_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                          s_axis_tuser_i  = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [qmlw_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic [qmlw_pkg::CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [qmlw_pkg::CfgDataW-1:0] cfg_data_i      = '0;

  // Predictor state: register file and stored motor speeds
  qmlw_pkg::cfg_t settings = {qmlw_pkg::MinSpeedRst, qmlw_pkg::MaxSpeedRst,
                              qmlw_pkg::LagGainRst, qmlw_pkg::ThrustCoeffRst,
                              qmlw_pkg::ArmCoeffRst, qmlw_pkg::YawCoeffRst};
  logic [31:0] motor_q [qmlw_pkg::NumMotors] = '{default: '0};
  logic [15:0] last_cmd [qmlw_pkg::NumMotors] = '{default: '0};

  wrench_t     expected_wrench [$];
  wrench_t     want, seen;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned burst_ask   = 0;
  int unsigned burst_seen  = 0;
  int unsigned burst_left  = 0;
  bit          stream_busy = 1'b0;
  bit          cfg_busy    = 1'b0;

  // Directed table: extremes, saturation, preset, crossed bounds, zero and full gain,
  // zero and full coefficients, spare indexes, masked overrange writes
  plan_row_t directed_plan [36] = '{
    '{ROW_REQ, OP_PRESET, '{16'd0, 16'd0, 16'd0, 16'd0}, 3'd0, 18'd0, 1'b1,
      '{20'd0, 18'sd0, 18'sd0, 18'sd0, '{16'd0, 16'd0, 16'd0, 16'd0}}},
    '{ROW_REQ, OP_STEP, '{16'd0, 16'd0, 16'd0, 16'd0}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_STEP, '{16'd65535, 16'd65535, 16'd65535, 16'd65535}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_PRESET, '{16'd65535, 16'd65535, 16'd65535, 16'd65535}, 3'd0, 18'd0, 1'b1,
      '{ThrustSat, 18'sd0, 18'sd0, 18'sd0, '{16'd65535, 16'd65535, 16'd65535, 16'd65535}}},
    '{ROW_REQ, OP_PRESET, '{16'd65535, 16'd0, 16'd65535, 16'd0}, 3'd0, 18'd0, 1'b1,
      '{ThrustSat, MomentHi, MomentLo, 18'sd0, '{16'd65535, 16'd0, 16'd65535, 16'd0}}},
    '{ROW_REQ, OP_PRESET, '{16'd0, 16'd65535, 16'd0, 16'd65535}, 3'd0, 18'd0, 1'b1,
      '{ThrustSat, MomentLo, MomentHi, 18'sd0, '{16'd0, 16'd65535, 16'd0, 16'd65535}}},
    '{ROW_REQ, OP_PRESET, '{16'd65535, 16'd65535, 16'd0, 16'd0}, 3'd0, 18'd0, 1'b1,
      '{ThrustSat, 18'sd0, 18'sd0, MomentHi, '{16'd65535, 16'd65535, 16'd0, 16'd0}}},
    '{ROW_REQ, OP_PRESET, '{16'd0, 16'd0, 16'd65535, 16'd65535}, 3'd0, 18'd0, 1'b1,
      '{ThrustSat, 18'sd0, 18'sd0, MomentLo, '{16'd0, 16'd0, 16'd65535, 16'd65535}}},
    '{ROW_REQ, OP_STEP, '{16'd100, 16'd7500, 16'd1500, 16'd20000}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_LAG_GAIN, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_STEP, '{16'd40000, 16'd3, 16'd9000, 16'd1234}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_MIN_SPEED, 18'd9000, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_MAX_SPEED, 18'd2000, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_LAG_GAIN, 18'd65535, 1'b0, '0},
    '{ROW_REQ, OP_STEP, '{16'd65535, 16'd0, 16'd5000, 16'd9500}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_THRUST_COEFF, 18'd0, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_ARM_COEFF, 18'd0, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_YAW_COEFF, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_PRESET, '{16'd65535, 16'd65535, 16'd65535, 16'd65535}, 3'd0, 18'd0, 1'b1,
      '{20'd0, 18'sd0, 18'sd0, 18'sd0, '{16'd65535, 16'd65535, 16'd65535, 16'd65535}}},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_THRUST_COEFF, 18'h3FFFF, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_ARM_COEFF, 18'h3FFFF, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_YAW_COEFF, 18'h3FFFF, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_MIN_SPEED, 18'h3FFFF, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_MAX_SPEED, 18'h3FFFF, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_LAG_GAIN, 18'h3FFFF, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, IdxSpare6, 18'd0, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, IdxSpare7, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_PRESET, '{16'd300, 16'd200, 16'd100, 16'd0}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_STEP, '{16'd0, 16'd0, 16'd0, 16'd0}, 3'd0, 18'd0, 1'b0, '0},
    '{ROW_REQ, OP_PRESET, '{16'd65535, 16'd0, 16'd0, 16'd0}, 3'd0, 18'd0, 1'b1,
      '{ThrustSat, 18'sd0, MomentLo, MomentHi, '{16'd65535, 16'd0, 16'd0, 16'd0}}},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_MIN_SPEED, 18'(qmlw_pkg::MinSpeedRst), 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_MAX_SPEED, 18'(qmlw_pkg::MaxSpeedRst), 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_LAG_GAIN, 18'(qmlw_pkg::LagGainRst), 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_THRUST_COEFF, qmlw_pkg::ThrustCoeffRst, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_ARM_COEFF, qmlw_pkg::ArmCoeffRst, 1'b0, '0},
    '{ROW_REG, OP_STEP, '0, qmlw_pkg::REG_YAW_COEFF, qmlw_pkg::YawCoeffRst, 1'b0, '0}
  };

  quad_motor_lag_wrench_step dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Scale a signed coefficient product down by 2^24 to a signed integer (Q18.0) and saturate to 18 bits
  function automatic logic signed [17:0] moment_q16(input longint signed prod);
    longint signed v;
    v = prod >>> 24;
    if (v > 131071) v = 131071;
    else if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  // Advance the motor speeds by one request and form the wrench it reports
  function automatic wrench_t advance_motors(input op_e op, input logic [0:3][15:0] cmds);
    wrench_t         w;
    logic [15:0]     cmd;
    longint signed   sq [qmlw_pkg::NumMotors];
    longint signed   delta;
    longint unsigned total, thrust;
    for (int k = 0; k < qmlw_pkg::NumMotors; k++) begin
      cmd = cmds[k];
      if (op == OP_PRESET) begin
        motor_q[k] = 32'(longint'(cmd) << FracBits);
      end else begin
        // Clamp: when the bounds cross, commands above the upper bound take it, all others the lower
        if (cmd > settings.max_speed) cmd = 16'(settings.max_speed);
        else if (cmd < settings.min_speed) cmd = 16'(settings.min_speed);
        delta = ((longint'(cmd) << FracBits) - longint'(motor_q[k]))
                * longint'(settings.lag_gain);
        delta = delta >>> 16;
        motor_q[k] = motor_q[k] + 32'(delta);
      end
      w.speed_now[k] = 16'(motor_q[k] >> FracBits);
      sq[k] = longint'(w.speed_now[k]) * longint'(w.speed_now[k]);
    end
    total  = sq[0] + sq[1] + sq[2] + sq[3];
    thrust = (total * settings.thrust_coeff) >> 24;
    if (thrust > 1048575) thrust = 1048575;
    w.thrust = 20'(thrust);
    w.roll   = moment_q16((sq[2] - sq[3]) * longint'(settings.arm_coeff));
    w.pitch  = moment_q16((sq[1] - sq[0]) * longint'(settings.arm_coeff));
    w.yaw    = moment_q16((sq[0] + sq[1] - sq[2] - sq[3]) * longint'(settings.yaw_coeff));
    return w;
  endfunction

  // Mirror a register write into the predictor; spare indexes change nothing
  function automatic void apply_reg(input logic [qmlw_pkg::CfgIdxW-1:0] idx,
                                    input logic [qmlw_pkg::CfgDataW-1:0] val);
    case (idx)
      qmlw_pkg::REG_MIN_SPEED:    settings.min_speed    = val[13:0];
      qmlw_pkg::REG_MAX_SPEED:    settings.max_speed    = val[13:0];
      qmlw_pkg::REG_LAG_GAIN:     settings.lag_gain     = val[15:0];
      qmlw_pkg::REG_THRUST_COEFF: settings.thrust_coeff = val;
      qmlw_pkg::REG_ARM_COEFF:    settings.arm_coeff    = val;
      qmlw_pkg::REG_YAW_COEFF:    settings.yaw_coeff    = val;
      default: ;
    endcase
  endfunction

  function automatic logic [17:0] pick_value(input int unsigned bits, input int unsigned hi);
    case ($urandom_range(5))
      0:       return '0;
      1:       return 18'((1 << bits) - 1);
      default: return 18'($urandom_range(hi, 0));
    endcase
  endfunction

  // Mostly held or in-range commands so the lag settles, with some noise and extremes
  function automatic logic [15:0] pick_command(input int k);
    case ($urandom_range(9))
      0, 1, 2: ;
      3:       last_cmd[k] = 16'($urandom);
      4:       last_cmd[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: last_cmd[k] = 16'($urandom_range(12000, 0));
    endcase
    return last_cmd[k];
  endfunction

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $error("%s expected %0d got %0d", name, exp_v, got_v);
    end
  endfunction

  // Drop the config channel valid if a write burst just finished
  task automatic release_cfg();
    if (cfg_busy) cfg_valid_i <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  // Drop the request valid and wait until every expected result has come back
  task automatic settle_stream();
    if (stream_busy) s_axis_tvalid_i <= 1'b0;
    stream_busy = 1'b0;
    while (expected_wrench.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [qmlw_pkg::CfgIdxW-1:0] idx,
                           input logic [qmlw_pkg::CfgDataW-1:0] val);
    settle_stream();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_busy = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  // Offer one request, optionally after an idle gap, and log its expected wrench
  task automatic push_request(input op_e op, input logic [0:3][15:0] cmds,
                              input logic typed, input wrench_t typed_exp);
    logic [qmlw_pkg::InDataW-1:0] payload;
    wrench_t                      predicted;
    release_cfg();
    if ($urandom_range(99) < idle_pct) begin
      if (stream_busy) s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    for (int k = 0; k < qmlw_pkg::NumMotors; k++) payload[16*k +: 16] = cmds[k];
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= payload;
    s_axis_tuser_i  <= op;
    stream_busy = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = advance_motors(op, cmds);
    expected_wrench.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic load_random_settings();
    write_reg(qmlw_pkg::REG_MIN_SPEED,    {4'($urandom), 14'(pick_value(14, 4000))});
    write_reg(qmlw_pkg::REG_MAX_SPEED,    {4'($urandom), 14'(pick_value(14, 16383))});
    write_reg(qmlw_pkg::REG_LAG_GAIN,     {2'($urandom), 16'(pick_value(16, 65535))});
    write_reg(qmlw_pkg::REG_THRUST_COEFF, pick_value(18, 120000));
    write_reg(qmlw_pkg::REG_ARM_COEFF,    pick_value(18, 60000));
    write_reg(qmlw_pkg::REG_YAW_COEFF,    pick_value(18, 20000));
    write_reg($urandom_range(1) ? IdxSpare6 : IdxSpare7, 18'($urandom));
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int count, input bit squeeze);
    logic [0:3][15:0] cmds;
    op_e              op;
    load_random_settings();
    idle_pct  = send_pct;
    stall_pct = recv_pct;
    // Ask the receiver for a long hold-off while requests keep coming
    if (squeeze) burst_ask <= burst_ask + 1;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(9) == 0) ? OP_PRESET : OP_STEP;
      for (int k = 0; k < qmlw_pkg::NumMotors; k++) cmds[k] = pick_command(k);
      push_request(op, cmds, 1'b0, '0);
    end
  endtask

  // Drive result ready: random stalls, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (burst_left != 0) begin
      burst_left      <= burst_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (burst_seen != burst_ask) begin
      burst_seen      <= burst_ask;
      burst_left      <= HoldOffCycles;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.thrust = m_axis_tdata_o[19:0];
      seen.roll   = m_axis_tdata_o[37:20];
      seen.pitch  = m_axis_tdata_o[55:38];
      seen.yaw    = m_axis_tdata_o[73:56];
      seen.speed_now[0] = m_axis_tdata_o[89:74];
      seen.speed_now[1] = m_axis_tdata_o[105:90];
      seen.speed_now[2] = m_axis_tdata_o[121:106];
      seen.speed_now[3] = m_axis_tdata_o[137:122];
      if (expected_wrench.size() == 0) begin
        mismatches++;
        $error("result delivered with no request outstanding");
      end else begin
        want = expected_wrench.pop_front();
        check_field("thrust", want.thrust, seen.thrust);
        check_field("roll_moment", want.roll, seen.roll);
        check_field("pitch_moment", want.pitch, seen.pitch);
        check_field("yaw_moment", want.yaw, seen.yaw);
        check_field("speed_now_0", want.speed_now[0], seen.speed_now[0]);
        check_field("speed_now_1", want.speed_now[1], seen.speed_now[1]);
        check_field("speed_now_2", want.speed_now[2], seen.speed_now[2]);
        check_field("speed_now_3", want.speed_now[3], seen.speed_now[3]);
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("quad_motor_lag_wrench_step verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG)
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      else
        push_request(directed_plan[i].op, directed_plan[i].cmds,
                     directed_plan[i].typed, directed_plan[i].expected);
    end

    // Random phases: free flow, sender gaps, receiver stalls, both, then back-pressure
    run_phase(0, 0, 130, 1'b0);
    run_phase(53, 0, 130, 1'b0);
    run_phase(0, 53, 130, 1'b0);
    run_phase(8, 8, 130, 1'b0);
    run_phase(0, 0, 60, 1'b1);

    release_cfg();
    settle_stream();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("quad_motor_lag_wrench_step verification clean");
    end else begin
      $display("quad_motor_lag_wrench_step verification failed");
    end
    $finish;
  end

endmodule

### quad_motor_lag_wrench_step.f
sv/qmlw_pkg.sv
sv/qmlw_ram.sv
sv/qmlw_motor.sv
sv/qmlw_wrench.sv
sv/quad_motor_lag_wrench_step.sv
verif/testbench.sv
